// File: rtl/core/clc_pkg.sv
package clc_pkg;

	localparam int MAX_CLUSTERS_DEF = 16;
	localparam int COLOR_BITS_DEF   = 16;
	localparam int WEIGHT_BITS_DEF  = 20;

	localparam int LIMIT_W  = 34;
	localparam int SUM_W    = 48;
	localparam int WT_W     = 32;
	localparam int CH_W     = 16;
	localparam int MEAN_W   = 3 * CH_W;
	localparam int DIST_W   = 34;
	localparam int DIV_STEPS = SUM_W;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 34'd128849019;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_RDSUM,
		ST_ACC,
		ST_DIV,
		ST_WRITE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic [SUM_W-1:0] dividend;
		logic [WT_W-1:0] divisor;
	} div_req_t;

endpackage

// File: rtl/core/clc_ram.sv
module clc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/clc_div.sv
// Restoring divider, one quotient bit per cycle; quotient clamped to a channel.
module clc_div #(
	parameter int COLOR_BITS = clc_pkg::COLOR_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  clc_pkg::div_req_t req,
	output logic busy,
	output logic [clc_pkg::CH_W-1:0] quot
);

	localparam int SW = clc_pkg::SUM_W;
	localparam int WW = clc_pkg::WT_W;
	localparam int NS = clc_pkg::DIV_STEPS;
	localparam logic [SW-1:0] CMAX = SW'((64'd1 << COLOR_BITS) - 64'd1);

	logic [SW-1:0] q_q;
	logic [WW:0] rem_q;
	logic [WW-1:0] d_q;
	logic [$clog2(NS+1)-1:0] cnt_q;
	logic [WW:0] trial;
	logic [WW:0] shifted;

	always_comb begin
		shifted = {rem_q[WW-1:0], q_q[SW-1]};
		trial   = shifted - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= ($clog2(NS+1))'(NS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q   <= req.dividend;
			rem_q <= '0;
			d_q   <= req.divisor;
		end else if (cnt_q != '0) begin
			if (!trial[WW]) begin
				rem_q <= trial;
				q_q   <= {q_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q   <= {q_q[SW-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = (d_q == '0) ? '0 : (q_q > CMAX) ? CMAX[clc_pkg::CH_W-1:0]
		: q_q[clc_pkg::CH_W-1:0];

endmodule

// File: rtl/core/color_leader_clustering_unit.sv
// Online leader clustering of weighted RGB colours. An input transfer carries an
// island id, a Q0.16 colour and a weight; one result transfer follows with the
// joined or opened cluster, or a table-full flag. Per-cluster means and sums sit
// in single-port-read synchronous RAMs. An item that joins or opens a cluster
// is scanned against the N clusters in use (one RAM read a cycle), then goes through
// decide, sum read, accumulate, the serial divider (the three channel means in turn),
// write-back and hand-over of the result. An item dropped on a full table skips the
// sums and the divider. The result waits in an output register, so the next input
// transfer is taken in the cycle after hand-over even while the receiver stalls.
// One item is processed at a time.
module color_leader_clustering_unit #(
	parameter int MAX_CLUSTERS = clc_pkg::MAX_CLUSTERS_DEF,
	parameter int COLOR_BITS   = clc_pkg::COLOR_BITS_DEF,
	parameter int WEIGHT_BITS  = clc_pkg::WEIGHT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [clc_pkg::LIMIT_W-1:0] cfg_wdata,
	input  logic s_tvalid,
	output logic s_tready,
	// island_id, red, green, blue, sample_weight, zero pad
	input  logic [87:0] s_tdata,
	// first_of_run
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// island_tag, cluster_index, opened_new, table_full, zero pad
	output logic [23:0] m_tdata
);

	localparam int AW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int CW  = $clog2(MAX_CLUSTERS + 1);
	localparam int SW  = clc_pkg::SUM_W;
	localparam int WW  = clc_pkg::WT_W;
	localparam int HW  = clc_pkg::CH_W;
	localparam int MW  = clc_pkg::MEAN_W;
	localparam int DW  = clc_pkg::DIST_W;
	localparam int ACC_W = 3 * SW + WW;
	localparam logic [SW-1:0] SUM_MAX = '1;
	localparam logic [WW-1:0] WT_MAX  = '1;

	clc_pkg::state_t state_q, state_d;

	logic [clc_pkg::LIMIT_W-1:0] limit_q;
	logic [CW-1:0] used_q;
	logic [15:0] id_q;
	logic [COLOR_BITS-1:0] r_q, g_q, b_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [CW-1:0] k_q;
	logic [AW-1:0] best_q;
	logic found_q, opened_q, full_q;
	logic [DW-1:0] best_d_q;
	logic cmp_vld_s1;
	logic [AW-1:0] cmp_k_s1;
	logic [SW-1:0] rs_q, gs_q, bs_q;
	logic [WW-1:0] wt_q;
	logic [1:0] ch_q;
	logic [HW-1:0] mr_q, mg_q;
	logic [HW-1:0] mb_d;
	logic div_started_q;
	logic out_vld_q;
	logic [23:0] out_data_q;

	// memories
	logic mean_we, acc_we;
	logic [AW-1:0] mean_raddr, acc_raddr;
	logic [MW-1:0] mean_rdata, mean_wdata;
	logic [ACC_W-1:0] acc_rdata, acc_wdata;

	clc_ram #(.WIDTH(MW), .DEPTH(MAX_CLUSTERS)) u_mean (
		.clk(clk), .we(mean_we), .waddr(best_q), .wdata(mean_wdata),
		.raddr(mean_raddr), .rdata(mean_rdata)
	);

	clc_ram #(.WIDTH(ACC_W), .DEPTH(MAX_CLUSTERS)) u_acc (
		.clk(clk), .we(acc_we), .waddr(best_q), .wdata(acc_wdata),
		.raddr(acc_raddr), .rdata(acc_rdata)
	);

	clc_pkg::div_req_t div_req;
	logic div_busy;
	logic [HW-1:0] div_quot;

	clc_div #(.COLOR_BITS(COLOR_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .busy(div_busy), .quot(div_quot)
	);

	wire s_xfer = s_tvalid && s_tready;
	wire m_xfer = m_tvalid && m_tready;
	// hand the result over once the output register is free or drains this cycle
	wire out_load = (state_q == clc_pkg::ST_OUT) && (!out_vld_q || m_xfer);

	// distance of the mean read last cycle
	logic [HW:0] dr, dg, db;
	logic [DW-1:0] sq_dist;
	logic [2*HW-1:0] sr, sg, sb;
	always_comb begin
		dr = {1'b0, HW'(r_q)} - {1'b0, mean_rdata[3*HW-1:2*HW]};
		dg = {1'b0, HW'(g_q)} - {1'b0, mean_rdata[2*HW-1:HW]};
		db = {1'b0, HW'(b_q)} - {1'b0, mean_rdata[HW-1:0]};
		if (dr[HW]) dr = -dr;
		if (dg[HW]) dg = -dg;
		if (db[HW]) db = -db;
		sr = dr[HW-1:0] * dr[HW-1:0];
		sg = dg[HW-1:0] * dg[HW-1:0];
		sb = db[HW-1:0] * db[HW-1:0];
		sq_dist = DW'(sr) + DW'(sg) + DW'(sb);
	end

	// accumulate
	logic [SW-1:0] pr, pg, pb;
	logic [SW:0] ar, ag, ab;
	logic [WW:0] aw;
	always_comb begin
		pr = SW'(r_q) * SW'(w_q);
		pg = SW'(g_q) * SW'(w_q);
		pb = SW'(b_q) * SW'(w_q);
		ar = {1'b0, rs_q} + {1'b0, pr};
		ag = {1'b0, gs_q} + {1'b0, pg};
		ab = {1'b0, bs_q} + {1'b0, pb};
		aw = {1'b0, wt_q} + {1'b0, WW'(w_q)};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			clc_pkg::ST_IDLE:   if (s_xfer) state_d = clc_pkg::ST_SCAN;
			clc_pkg::ST_SCAN:   if (k_q >= used_q && !cmp_vld_s1) state_d = clc_pkg::ST_DECIDE;
			// drop the item straight to the result when the table is full
			clc_pkg::ST_DECIDE:
				state_d = (!found_q && used_q >= CW'(MAX_CLUSTERS)) ? clc_pkg::ST_OUT
					: clc_pkg::ST_RDSUM;
			clc_pkg::ST_RDSUM:  state_d = clc_pkg::ST_ACC;
			clc_pkg::ST_ACC:    state_d = clc_pkg::ST_DIV;
			clc_pkg::ST_DIV:
				if (div_started_q && !div_busy && ch_q == 2'd2) state_d = clc_pkg::ST_WRITE;
			clc_pkg::ST_WRITE:  state_d = clc_pkg::ST_OUT;
			clc_pkg::ST_OUT:    if (out_load) state_d = clc_pkg::ST_IDLE;
			default:            state_d = clc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == clc_pkg::ST_IDLE);
		m_tvalid   = out_vld_q;
		mean_raddr = k_q[AW-1:0];
		acc_raddr  = best_q;
		mean_we    = (state_q == clc_pkg::ST_WRITE);
		acc_we     = (state_q == clc_pkg::ST_WRITE);
		mb_d       = div_quot;
		mean_wdata = {mr_q, mg_q, mb_d};
		acc_wdata  = {rs_q, gs_q, bs_q, wt_q};
		div_req.start    = (state_q == clc_pkg::ST_DIV) && (!div_started_q ||
			(!div_busy && ch_q != 2'd2));
		div_req.divisor  = wt_q;
		case (div_started_q ? ch_q + 2'd1 : 2'd0)
			2'd0:    div_req.dividend = rs_q;
			2'd1:    div_req.dividend = gs_q;
			default: div_req.dividend = bs_q;
		endcase
		m_tdata = out_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clc_pkg::ST_IDLE;
			limit_q <= clc_pkg::LIMIT_RESET;
			used_q  <= '0;
			cmp_vld_s1 <= 1'b0;
			div_started_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				limit_q <= cfg_wdata;
			if (s_xfer && s_tuser)
				used_q <= '0;
			if (state_q == clc_pkg::ST_DECIDE && !found_q && used_q < CW'(MAX_CLUSTERS))
				used_q <= used_q + 1'b1;
			cmp_vld_s1 <= (state_q == clc_pkg::ST_SCAN) && (k_q < used_q);
			if (state_q == clc_pkg::ST_DIV) begin
				if (div_req.start)
					div_started_q <= 1'b1;
			end else begin
				div_started_q <= 1'b0;
			end
			if (out_load)
				out_vld_q <= 1'b1;
			else if (m_xfer)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cmp_k_s1 <= k_q[AW-1:0];
		if (out_load)
			out_data_q <= {2'b00, full_q, opened_q, 4'(best_q), id_q};
		case (state_q)
			clc_pkg::ST_IDLE: if (s_xfer) begin
				id_q <= s_tdata[15:0];
				r_q  <= s_tdata[16 +: COLOR_BITS];
				g_q  <= s_tdata[32 +: COLOR_BITS];
				b_q  <= s_tdata[48 +: COLOR_BITS];
				w_q  <= s_tdata[64 +: WEIGHT_BITS];
				k_q  <= '0;
				found_q <= 1'b0;
				opened_q <= 1'b0;
				full_q <= 1'b0;
				best_q <= '0;
				best_d_q <= '0;
			end
			clc_pkg::ST_SCAN: begin
				if (k_q < used_q)
					k_q <= k_q + 1'b1;
				if (cmp_vld_s1 && DW'(sq_dist) <= limit_q &&
				    (!found_q || sq_dist < best_d_q)) begin
					found_q <= 1'b1;
					best_d_q <= sq_dist;
					best_q <= cmp_k_s1;
				end
				if (k_q >= used_q && !cmp_vld_s1 && !(cmp_vld_s1))
					full_q <= 1'b0;
			end
			clc_pkg::ST_DECIDE: begin
				if (!found_q) begin
					if (used_q < CW'(MAX_CLUSTERS)) begin
						best_q <= used_q[AW-1:0];
						opened_q <= 1'b1;
					end else begin
						best_q <= '0;
						full_q <= 1'b1;
					end
				end
				ch_q <= 2'd0;
			end
			clc_pkg::ST_ACC: begin
				if (opened_q) begin
					rs_q <= SW'(pr);
					gs_q <= SW'(pg);
					bs_q <= SW'(pb);
					wt_q <= WW'(w_q);
				end else begin
					rs_q <= ar[SW] ? SUM_MAX : ar[SW-1:0];
					gs_q <= ag[SW] ? SUM_MAX : ag[SW-1:0];
					bs_q <= ab[SW] ? SUM_MAX : ab[SW-1:0];
					wt_q <= aw[WW] ? WT_MAX : aw[WW-1:0];
				end
			end
			clc_pkg::ST_DIV: if (div_started_q && !div_busy && ch_q != 2'd2) begin
				if (ch_q == 2'd0) mr_q <= div_quot;
				else mg_q <= div_quot;
				ch_q <= ch_q + 2'd1;
			end
			default: ;
		endcase
		if (state_q == clc_pkg::ST_RDSUM && !opened_q) begin
			rs_q <= acc_rdata[ACC_W-1 -: SW];
			gs_q <= acc_rdata[ACC_W-1-SW -: SW];
			bs_q <= acc_rdata[WW +: SW];
			wt_q <= acc_rdata[WW-1:0];
		end
	end

	a_out_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == clc_pkg::ST_OUT && m_tvalid && !m_tready |=> state_q == clc_pkg::ST_OUT)
		else $error("result handed over while output register busy");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(MAX_CLUSTERS)) else $error("cluster count overflow");
	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[21] && m_tdata[20])) else $error("full and opened both set");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int NCLUST = 16;
	localparam logic [47:0] SUM_SAT = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] WT_SAT  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [19:0] weight;
		logic        first;
	} island_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [3:0]  index;
		logic        opened;
		logic        full;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [clc_pkg::LIMIT_W-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [87:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [23:0] m_tdata;

	color_leader_clustering_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// predictor state
	logic [clc_pkg::LIMIT_W-1:0] lim;
	int unsigned        used;
	logic [47:0]        rsum [NCLUST];
	logic [47:0]        gsum [NCLUST];
	logic [47:0]        bsum [NCLUST];
	logic [31:0]        wtot [NCLUST];
	logic [15:0]        mr [NCLUST];
	logic [15:0]        mg [NCLUST];
	logic [15:0]        mb [NCLUST];

	verdict_t pending [$];
	int       errors;
	logic     hold_rx;

	function automatic logic [47:0] sat48(logic [47:0] a, logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? SUM_SAT : s[47:0];
	endfunction

	function automatic logic [15:0] mean_of(logic [47:0] s, logic [31:0] w);
		logic [47:0] q;
		if (w == 0)
			return 16'd0;
		q = s / w;
		return (q > 48'hFFFF) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic logic [33:0] sqd(logic [15:0] a, logic [15:0] b);
		logic [31:0] d;
		d = (a >= b) ? a - b : b - a;
		return 34'(d) * 34'(d);
	endfunction

	function automatic verdict_t assign_island(island_t it);
		verdict_t v;
		logic hit;
		logic [33:0] bestd, d;
		int best;
		logic [32:0] ws;
		hit = 0;
		bestd = 0;
		best = 0;
		v = '0;
		v.tag = it.id;
		if (it.first)
			used = 0;
		for (int k = 0; k < used; k++) begin
			d = sqd(it.red, mr[k]) + sqd(it.green, mg[k]) + sqd(it.blue, mb[k]);
			if (d <= lim && (!hit || d < bestd)) begin
				hit = 1;
				bestd = d;
				best = k;
			end
		end
		if (!hit) begin
			if (used < NCLUST) begin
				best = used;
				used++;
				rsum[best] = 0; gsum[best] = 0; bsum[best] = 0; wtot[best] = 0;
				v.opened = 1;
				hit = 1;
			end else begin
				v.full = 1;
				best = 0;
			end
		end
		if (hit) begin
			rsum[best] = sat48(rsum[best], 48'(it.red) * 48'(it.weight));
			gsum[best] = sat48(gsum[best], 48'(it.green) * 48'(it.weight));
			bsum[best] = sat48(bsum[best], 48'(it.blue) * 48'(it.weight));
			ws = {1'b0, wtot[best]} + 33'(it.weight);
			wtot[best] = ws[32] ? WT_SAT : ws[31:0];
			mr[best] = mean_of(rsum[best], wtot[best]);
			mg[best] = mean_of(gsum[best], wtot[best]);
			mb[best] = mean_of(bsum[best], wtot[best]);
		end
		v.index = best[3:0];
		return v;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("color_leader_clustering_unit regression: fail");
		$finish;
	end

	// offer one island; optionally check the typed-in verdict too
	task automatic offer(island_t it, logic known, verdict_t want);
		verdict_t v;
		s_tdata  <= {4'd0, it.weight, it.blue, it.green, it.red, it.id};
		s_tuser  <= it.first;
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		v = assign_island(it);
		if (known && v != want) begin
			$display("%0t table verdict %h, predictor %h", $time, want, v);
			errors++;
		end
		pending.push_back(v);
		if ($urandom_range(0, 3) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain_and_set(logic [clc_pkg::LIMIT_W-1:0] value);
		s_tvalid <= 0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		cfg_we    <= 1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 0;
		lim = value;
	endtask

	function automatic island_t rand_island(int palette);
		island_t it;
		logic [15:0] base;
		it.id = 16'($urandom);
		base = 16'($urandom_range(0, palette - 1)) * 16'(65535 / palette);
		it.red   = ($urandom_range(0, 7) == 0) ? 16'($urandom) : base + 16'($urandom_range(0, 300));
		it.green = ($urandom_range(0, 7) == 0) ? 16'($urandom) : base + 16'($urandom_range(0, 300));
		it.blue  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : base + 16'($urandom_range(0, 300));
		case ($urandom_range(0, 5))
			0: it.weight = 20'hFFFFF;
			1: it.weight = 20'($urandom_range(1, 4));
			default: it.weight = 20'($urandom);
		endcase
		if (it.weight == 0)
			it.weight = 1;
		it.first = ($urandom_range(0, 40) == 0);
		return it;
	endfunction

	typedef struct {
		island_t  it;
		logic     known;
		verdict_t want;
	} row_t;

	row_t rows [$];

	initial begin
		row_t r;
		logic [clc_pkg::LIMIT_W-1:0] limits [4];
		arst_n = 0; cfg_we = 0; cfg_wdata = '0;
		s_tvalid = 0; s_tdata = '0; s_tuser = 0;
		errors = 0; hold_rx = 0;
		lim = clc_pkg::LIMIT_RESET; used = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// first item after reset opens cluster 0
		r.it = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 20'd1, 1'b1};
		r.known = 1; r.want = '{16'h0000, 4'd0, 1'b1, 1'b0}; rows.push_back(r);
		r.it = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 1'b0};
		r.known = 1; r.want = '{16'hFFFF, 4'd1, 1'b1, 1'b0}; rows.push_back(r);
		r.it = '{16'h1234, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 1'b0};
		r.known = 1; r.want = '{16'h1234, 4'd1, 1'b0, 1'b0}; rows.push_back(r);
		r.it = '{16'h00AA, 16'h0000, 16'h0000, 16'h0000, 20'd0, 1'b0};
		r.known = 1; r.want = '{16'h00AA, 4'd0, 1'b0, 1'b0}; rows.push_back(r);
		// fill the table with colours on a coarse grid, then hit table full
		for (int k = 2; k < 16; k++) begin
			r.it = '{16'(k), 16'((k % 4) * 21845), 16'((k / 4) * 21845), 16'h0000,
				20'd7, 1'b0};
			r.known = 0; rows.push_back(r);
		end
		r.it = '{16'hBEEF, 16'h8000, 16'h0100, 16'hF000, 20'd3, 1'b0};
		r.known = 1; r.want = '{16'hBEEF, 4'd0, 1'b0, 1'b1}; rows.push_back(r);
		r.it = '{16'h5555, 16'h5555, 16'hAAAA, 16'h5555, 20'h55555, 1'b1};
		r.known = 1; r.want = '{16'h5555, 4'd0, 1'b1, 1'b0}; rows.push_back(r);
		foreach (rows[i])
			offer(rows[i].it, rows[i].known, rows[i].want);

		// long receiver hold-off while the sender keeps offering
		hold_rx = 1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_rx = 0;
			end
			for (int i = 0; i < 10; i++)
				offer(rand_island(8), 0, '0);
		join

		limits[0] = '0;
		limits[1] = {clc_pkg::LIMIT_W{1'b1}};
		limits[2] = clc_pkg::LIMIT_RESET;
		limits[3] = 34'd4000000;
		for (int ph = 0; ph < 4; ph++) begin
			drain_and_set(limits[ph]);
			for (int i = 0; i < 470; i++) begin
				island_t it;
				it = rand_island((ph == 0) ? 40 : 6);
				if ($urandom_range(0, 3) == 0)
					it.first = 0;
				offer(it, 0, '0);
			end
		end

		s_tvalid <= 0;
		while (pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("color_leader_clustering_unit regression: pass");
		else
			$display("color_leader_clustering_unit regression: fail");
		$finish;
	end

	// receiver: stall on its own pattern, with quiet stretches
	initial begin
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx)
				m_tready <= 0;
			else if (($time / 20000) % 3 == 0)
				m_tready <= 1;
			else
				m_tready <= ($urandom_range(0, 2) != 0);
		end
	end

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		verdict_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[15:0], m_tdata[19:16], m_tdata[20], m_tdata[21]};
			if (pending.size() == 0) begin
				$display("%0t unexpected result %h", $time, got);
				errors++;
			end else begin
				want = pending.pop_front();
				if (got.tag != want.tag || got.index != want.index ||
				    got.opened != want.opened || got.full != want.full) begin
					$display("%0t result mismatch: expected %h, got %h", $time, want, got);
					errors++;
				end
			end
		end
	end

endmodule
